@@ hdl/tor_pkg.sv @@
// shared types, constants and helpers for the telnet option responder
package tor_pkg;

  localparam logic [7:0] TN_IAC  = 8'hFF;
  localparam logic [7:0] TN_DONT = 8'hFE;
  localparam logic [7:0] TN_DO   = 8'hFD;
  localparam logic [7:0] TN_WONT = 8'hFC;
  localparam logic [7:0] TN_WILL = 8'hFB;
  localparam logic [7:0] TN_SB   = 8'hFA;
  localparam logic [7:0] TN_SE   = 8'hF0;
  localparam logic [7:0] TN_NAWS = 8'h1F;

  localparam logic [15:0] COLS_RESET = 16'd80;
  localparam logic [15:0] ROWS_RESET = 16'd24;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] JOB_ONE  = 2'd0;
  localparam logic [1:0] JOB_WONT = 2'd1;
  localparam logic [1:0] JOB_NAWS = 2'd2;

  localparam logic [3:0] NAWS_LAST = 4'd10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } job_t;

  function automatic logic [7:0] naws_byte(input logic [3:0] step,
                                           input logic [15:0] cols,
                                           input logic [15:0] rows);
    logic [7:0] b;
    case (step)
      4'd0:    b = TN_WILL;
      4'd1:    b = TN_NAWS;
      4'd2:    b = TN_IAC;
      4'd3:    b = TN_SB;
      4'd4:    b = TN_NAWS;
      4'd5:    b = cols[15:8];
      4'd6:    b = cols[7:0];
      4'd7:    b = rows[15:8];
      4'd8:    b = rows[7:0];
      4'd9:    b = TN_IAC;
      4'd10:   b = TN_SE;
      default: b = TN_SE;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/telnet_option_responder.sv @@
// telnet option responder top level: window size registers, parser, queue, sequencer
// the first reply byte of an item is registered in the job queue and then in the output register
// one item per cycle while each item causes at most one reply byte and the output is not stalled
// a window-size reply holds the sequencer for eleven reply bytes; a four-entry job queue absorbs input
// synchronous active-low reset: phase to idle, queue and output empty, sizes to 80 x 24
module telnet_option_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte [7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte [7:0]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import tor_pkg::*;

  logic [15:0] cols_r, cols_nxt;
  logic [15:0] rows_r, rows_nxt;
  logic        acc;
  logic        push;
  job_t        job;
  logic        full, empty, pop;
  job_t        head;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COLS: cols_nxt = cfg_wdata;
        CFG_ROWS: rows_nxt = cfg_wdata;
        default:  cols_nxt = cols_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  assign in_tready = ~full;
  assign acc       = in_tvalid & ~full;

  tor_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_tdata),
    .chunk_end (in_tlast),
    .push      (push),
    .job       (job)
  );

  tor_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  tor_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (~empty),
    .head       (head),
    .cols       (cols_r),
    .rows       (rows_r),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hdl/tor_front.sv @@
// command parser: tracks the telnet phase and turns accepted bytes into reply jobs where a reply is due
module tor_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        rx_byte,
  input  logic              chunk_end,
  output logic              push,
  output tor_pkg::job_t     job
);
  import tor_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_IAC  = 2'd1;
  localparam logic [1:0] PH_DO   = 2'd2;
  localparam logic [1:0] PH_ECHO = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] next_ph;
  logic       emit;

  always_comb begin
    next_ph  = PH_IDLE;
    emit     = 1'b0;
    job.kind = JOB_ONE;
    job.data = rx_byte;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == TN_IAC) begin
          emit    = 1'b1;
          next_ph = PH_IAC;
        end
      end
      PH_IAC: begin
        if (rx_byte == TN_IAC) begin
          emit    = 1'b1;
          next_ph = PH_IAC;
        end else if (rx_byte == TN_DO) begin
          next_ph = PH_DO;
        end else if (rx_byte == TN_WILL) begin
          emit     = 1'b1;
          job.data = TN_DO;
          next_ph  = PH_ECHO;
        end else begin
          emit    = 1'b1;
          next_ph = (rx_byte == TN_WONT || rx_byte == TN_DONT) ? PH_ECHO : PH_IDLE;
        end
      end
      PH_DO: begin
        emit     = 1'b1;
        job.kind = (rx_byte == TN_NAWS) ? JOB_NAWS : JOB_WONT;
      end
      default: begin
        emit = 1'b1;
      end
    endcase
  end

  assign push      = acc & emit;
  assign phase_nxt = acc ? (chunk_end ? PH_IDLE : next_ph) : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ hdl/tor_queue.sv @@
// short job queue between parser and reply sequencer
module tor_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tor_pkg::job_t     push_job,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output tor_pkg::job_t     head
);
  import tor_pkg::*;

  job_t                mem_r [QDEPTH];
  logic [QAW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]        cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == QDEPTH[QAW:0]);
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/tor_back.sv @@
// reply sequencer: expands queued jobs into reply bytes behind an output register
module tor_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  tor_pkg::job_t     head,
  input  logic [15:0]       cols,
  input  logic [15:0]       rows,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);
  import tor_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       fin;
  logic [7:0] byte_sel;

  assign load = head_valid & (~vld_r | out_tready);

  always_comb begin
    case (head.kind)
      JOB_WONT: begin
        byte_sel = (step_r == 4'd0) ? TN_WONT : head.data;
        fin      = (step_r == 4'd1);
      end
      JOB_NAWS: begin
        byte_sel = naws_byte(step_r, cols, rows);
        fin      = (step_r == NAWS_LAST);
      end
      default: begin
        byte_sel = head.data;
        fin      = 1'b1;
      end
    endcase
  end

  assign pop = load & fin;

  always_comb begin
    step_nxt = step_r;
    vld_nxt  = vld_r;
    data_nxt = data_r;
    last_nxt = last_r;
    if (load) begin
      vld_nxt  = 1'b1;
      data_nxt = byte_sel;
      last_nxt = fin;
      step_nxt = fin ? 4'd0 : step_r + 4'd1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 4'd0;
      vld_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

@@ hdl/tor_checker.sv @@
// port checker for the telnet option responder, bound to the top level
module tor_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  a_rst_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("reply item shown right after reset");

  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled reply item changed");

endmodule

bind telnet_option_responder tor_checker u_tor_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
